### hdl/sqvs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sqvs_pkg
// Shared types, constants and divider helpers for the sprite quad vertex setup.
// ----------------------------------------------------------------------------
package sqvs_pkg;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam int          SINE_W      = 16;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_TEX_WIDTH  = 2'd0,
    REG_TEX_HEIGHT = 2'd1,
    REG_USE_REGION = 2'd2,
    REG_FLIP_V     = 2'd3
  } reg_index_t;

  localparam logic [16:0] TEX_ONE  = 17'd65536;
  localparam logic [16:0] TEX_HALF = 17'd32768;

  // long division state: remainder, quotient, numerator low bits, saturate flag
  typedef struct packed {
    logic [12:0] r;
    logic [15:0] q;
    logic [15:0] lo;
    logic        sat;
  } div_t;

  function automatic div_t div_init(logic [13:0] e, logic [12:0] s);
    div_t o;
    o.sat = (e >= {1'b0, s});
    o.r   = o.sat ? 13'd0 : e[12:0];
    o.q   = 16'd0;
    o.lo  = {4'd0, s[12:1]};
    return o;
  endfunction

  // four restoring division steps
  function automatic div_t div_step4(div_t d, logic [12:0] s);
    div_t        o;
    logic [13:0] t;
    o = d;
    for (int n = 0; n < 4; n++) begin
      t    = {o.r, o.lo[15]};
      o.lo = {o.lo[14:0], 1'b0};
      if (t >= {1'b0, s}) begin
        o.r = 13'(t - {1'b0, s});
        o.q = {o.q[14:0], 1'b1};
      end else begin
        o.r = t[12:0];
        o.q = {o.q[14:0], 1'b0};
      end
    end
    return o;
  endfunction

  function automatic logic [16:0] div_result(div_t d);
    return d.sat ? TEX_ONE : {1'b0, d.q};
  endfunction

endpackage

### hdl/sqvs_sine_rom.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sqvs_sine_rom
// Quarter-wave sine table in Q1.15, filled at start-up, two registered reads.
// ----------------------------------------------------------------------------
module sqvs_sine_rom #(
  parameter int SINE_TABLE_DEPTH = 1024,
  parameter int AW               = $clog2(SINE_TABLE_DEPTH + 1)
) (
  input  logic                        clk,
  input  logic                        en,
  input  logic [AW-1:0]               addr_a,
  input  logic [AW-1:0]               addr_b,
  output logic [sqvs_pkg::SINE_W-1:0] data_a,
  output logic [sqvs_pkg::SINE_W-1:0] data_b
);

  // taylor series of sin(k*pi/(2*depth)) in Q2.30, rounded to Q1.15
  function automatic logic [sqvs_pkg::SINE_W-1:0] sine_entry(int k);
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    x    = (64'(k) * sqvs_pkg::HALF_PI_Q30 + 64'(SINE_TABLE_DEPTH / 2))
           / 64'(SINE_TABLE_DEPTH);
    x2   = (x * x) >> 30;
    term = x;
    sum  = $signed(x);
    term = ((term * x2) >> 30) / 64'd6;   sum = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd20;  sum = sum + $signed(term);
    term = ((term * x2) >> 30) / 64'd42;  sum = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd72;  sum = sum + $signed(term);
    term = ((term * x2) >> 30) / 64'd110; sum = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd156; sum = sum + $signed(term);
    if (sum < 0) return '0;
    sum = (sum + 64'sd16384) >>> 15;
    if (sum > 64'sd32768) sum = 64'sd32768;
    return sum[sqvs_pkg::SINE_W-1:0];
  endfunction

  logic [sqvs_pkg::SINE_W-1:0] rom [SINE_TABLE_DEPTH+1];

  initial begin
    for (int k = 0; k <= SINE_TABLE_DEPTH; k++) begin
      rom[k] = sine_entry(k);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data_a <= rom[addr_a];
      data_b <= rom[addr_b];
    end
  end

endmodule

### hdl/sprite_quad_vertex_setup.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sprite_quad_vertex_setup
// Rotates and scales one sprite into four corner vertices with texture coords.
// ----------------------------------------------------------------------------
// pipeline: an accepted sprite passes the stage 1 to 4 registers and the corner buffer
//   before its top-left corner shows on m_tdata; output rate is bounded by the four corner
//   transactions per sprite, the five-stage pipeline itself takes one sprite per cycle unless stalled
// reset: clears all valid bits and the corner counter, registers go to
//   tex_width 1, tex_height 1, use_texture_region 1, flip_v 0
module sprite_quad_vertex_setup #(
  parameter int SINE_TABLE_DEPTH = 1024
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [12:0]  cfg_data,
  input  logic         s_tvalid,
  output logic         s_tready,
  // pos_x, pos_y, src_x, src_y, src_w, src_h, origin_x, origin_y, angle,
  // scale_x, scale_y, zero pad
  input  logic [183:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // corner, vert_x, vert_y, tex_u, tex_v, zero pad
  output logic [87:0]  m_tdata,
  output logic         m_tlast
);

  localparam int AW = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int PW = 14 + AW;

  // configuration
  logic [12:0] tex_width, tex_height;
  logic        use_texture_region, flip_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      tex_width          <= 13'd1;
      tex_height         <= 13'd1;
      use_texture_region <= 1'b1;
      flip_v             <= 1'b0;
    end else if (cfg_we) begin
      case (sqvs_pkg::reg_index_t'(cfg_index))
        sqvs_pkg::REG_TEX_WIDTH:  tex_width          <= cfg_data;
        sqvs_pkg::REG_TEX_HEIGHT: tex_height         <= cfg_data;
        sqvs_pkg::REG_USE_REGION: use_texture_region <= cfg_data[0];
        sqvs_pkg::REG_FLIP_V:     flip_v             <= cfg_data[0];
        default: ;
      endcase
    end
  end

  logic [12:0] sw, sh;
  assign sw = (tex_width == 13'd0) ? 13'd1 : tex_width;
  assign sh = (tex_height == 13'd0) ? 13'd1 : tex_height;

  // input fields
  logic signed [23:0] in_pos_x, in_pos_y;
  logic [11:0]        in_src_x, in_src_y;
  logic [12:0]        in_src_w, in_src_h;
  logic signed [16:0] in_org_x, in_org_y;
  logic [15:0]        in_angle, in_scl_x, in_scl_y;

  assign in_pos_x = $signed(s_tdata[23:0]);
  assign in_pos_y = $signed(s_tdata[47:24]);
  assign in_src_x = s_tdata[59:48];
  assign in_src_y = s_tdata[71:60];
  assign in_src_w = s_tdata[84:72];
  assign in_src_h = s_tdata[97:85];
  assign in_org_x = $signed(s_tdata[114:98]);
  assign in_org_y = $signed(s_tdata[131:115]);
  assign in_angle = s_tdata[147:132];
  assign in_scl_x = s_tdata[163:148];
  assign in_scl_y = s_tdata[179:164];

  // flow control
  logic v1, v2, v3, v4, fv;
  logic [1:0] cnt;
  logic en1, en2, en3, en4, en_buf, last_xfer;

  assign last_xfer = fv && m_tready && (cnt == 2'd3);
  assign en_buf    = !fv || last_xfer;
  assign en4       = en_buf || !v4;
  assign en3       = en4 || !v3;
  assign en2       = en3 || !v2;
  assign en1       = en2 || !v1;
  assign s_tready  = en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1  <= 1'b0;
      v2  <= 1'b0;
      v3  <= 1'b0;
      v4  <= 1'b0;
      fv  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (en1) v1 <= s_tvalid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
      if (en_buf) begin
        fv  <= v4;
        cnt <= 2'd0;
      end else if (m_tready) begin
        cnt <= cnt + 2'd1;
      end
    end
  end

  // stage 1: scale products, table addresses, divider setup
  logic [PW-1:0]      ang_prod;
  logic signed [32:0] s1_ox, s1_oy;
  logic [28:0]        s1_wt, s1_ht;
  logic [1:0]         s1_quad;
  logic [AW-1:0]      s1_ia, s1_ib;
  logic signed [23:0] s1_px, s1_py;
  sqvs_pkg::div_t     s1_dl, s1_dr, s1_dt, s1_db;

  assign ang_prod = PW'(in_angle[13:0]) * PW'(SINE_TABLE_DEPTH);

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_ox   <= $signed(in_org_x) * $signed({1'b0, in_scl_x});
      s1_oy   <= $signed(in_org_y) * $signed({1'b0, in_scl_y});
      s1_wt   <= 29'(in_src_w) * 29'(in_scl_x);
      s1_ht   <= 29'(in_src_h) * 29'(in_scl_y);
      s1_quad <= in_angle[15:14];
      s1_ia   <= ang_prod[PW-1:14];
      s1_ib   <= AW'(SINE_TABLE_DEPTH) - ang_prod[PW-1:14];
      s1_px   <= in_pos_x;
      s1_py   <= in_pos_y;
      s1_dl   <= sqvs_pkg::div_init(14'(in_src_x), sw);
      s1_dr   <= sqvs_pkg::div_init(14'(in_src_x) + 14'(in_src_w), sw);
      s1_dt   <= sqvs_pkg::div_init(14'(in_src_y), sh);
      s1_db   <= sqvs_pkg::div_init(14'(in_src_y) + 14'(in_src_h), sh);
    end
  end

  // stage 2: corner vectors, table read, divider steps
  logic [sqvs_pkg::SINE_W-1:0] ta, tb;
  logic signed [34:0]          s2_xl, s2_xr, s2_yt, s2_yb;
  logic [1:0]                  s2_quad;
  logic signed [23:0]          s2_px, s2_py;
  sqvs_pkg::div_t              s2_dl, s2_dr, s2_dt, s2_db;

  sqvs_sine_rom #(
    .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH),
    .AW              (AW)
  ) u_rom (
    .clk   (clk),
    .en    (en2),
    .addr_a(s1_ia),
    .addr_b(s1_ib),
    .data_a(ta),
    .data_b(tb)
  );

  always_ff @(posedge clk) begin
    if (en2) begin
      s2_xl   <= 35'(s1_ox);
      s2_xr   <= 35'(s1_ox) + 35'($signed({1'b0, s1_wt, 4'b0000}));
      s2_yt   <= 35'(s1_oy);
      s2_yb   <= 35'(s1_oy) + 35'($signed({1'b0, s1_ht, 4'b0000}));
      s2_quad <= s1_quad;
      s2_px   <= s1_px;
      s2_py   <= s1_py;
      s2_dl   <= sqvs_pkg::div_step4(s1_dl, sw);
      s2_dr   <= sqvs_pkg::div_step4(s1_dr, sw);
      s2_dt   <= sqvs_pkg::div_step4(s1_dt, sh);
      s2_db   <= sqvs_pkg::div_step4(s1_db, sh);
    end
  end

  // stage 3: rotation products, divider steps
  logic signed [16:0] ta_s, tb_s, sn, cs;
  logic signed [51:0] s3_xlc, s3_xrc, s3_yts, s3_ybs, s3_xls, s3_xrs, s3_ytc, s3_ybc;
  logic signed [23:0] s3_px, s3_py;
  sqvs_pkg::div_t     s3_dl, s3_dr, s3_dt, s3_db;

  assign ta_s = $signed({1'b0, ta});
  assign tb_s = $signed({1'b0, tb});

  always_comb begin
    case (s2_quad)
      2'd0: begin sn = ta_s;  cs = tb_s;  end
      2'd1: begin sn = tb_s;  cs = -ta_s; end
      2'd2: begin sn = -ta_s; cs = -tb_s; end
      default: begin sn = -tb_s; cs = ta_s; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      s3_xlc <= s2_xl * cs;
      s3_xrc <= s2_xr * cs;
      s3_yts <= s2_yt * sn;
      s3_ybs <= s2_yb * sn;
      s3_xls <= s2_xl * sn;
      s3_xrs <= s2_xr * sn;
      s3_ytc <= s2_yt * cs;
      s3_ybc <= s2_yb * cs;
      s3_px  <= s2_px;
      s3_py  <= s2_py;
      s3_dl  <= sqvs_pkg::div_step4(s2_dl, sw);
      s3_dr  <= sqvs_pkg::div_step4(s2_dr, sw);
      s3_dt  <= sqvs_pkg::div_step4(s2_dt, sh);
      s3_db  <= sqvs_pkg::div_step4(s2_db, sh);
    end
  end

  // stage 4: sums rounded to Q.8, divider steps
  function automatic logic signed [33:0] round_q8(logic signed [52:0] v);
    logic signed [52:0] t;
    t = (v + 53'sd262144) >>> 19;
    return $signed(t[33:0]);
  endfunction

  logic signed [33:0] s4_rx [4];
  logic signed [33:0] s4_ry [4];
  logic signed [23:0] s4_px, s4_py;
  sqvs_pkg::div_t     s4_dl, s4_dr, s4_dt, s4_db;

  always_ff @(posedge clk) begin
    if (en4) begin
      s4_rx[0] <= round_q8(53'(s3_xlc) - 53'(s3_yts));
      s4_rx[1] <= round_q8(53'(s3_xrc) - 53'(s3_yts));
      s4_rx[2] <= round_q8(53'(s3_xlc) - 53'(s3_ybs));
      s4_rx[3] <= round_q8(53'(s3_xrc) - 53'(s3_ybs));
      s4_ry[0] <= round_q8(53'(s3_xls) + 53'(s3_ytc));
      s4_ry[1] <= round_q8(53'(s3_xrs) + 53'(s3_ytc));
      s4_ry[2] <= round_q8(53'(s3_xls) + 53'(s3_ybc));
      s4_ry[3] <= round_q8(53'(s3_xrs) + 53'(s3_ybc));
      s4_px    <= s3_px;
      s4_py    <= s3_py;
      s4_dl    <= sqvs_pkg::div_step4(s3_dl, sw);
      s4_dr    <= sqvs_pkg::div_step4(s3_dr, sw);
      s4_dt    <= sqvs_pkg::div_step4(s3_dt, sh);
      s4_db    <= sqvs_pkg::div_step4(s3_db, sh);
    end
  end

  // stage 5: corner buffer, saturated positions and final coordinates
  function automatic logic [23:0] sat_vert(logic signed [23:0] p, logic signed [33:0] r);
    logic signed [34:0] t;
    t = 35'(p) + 35'(r);
    if (t > 35'sd8388607) return 24'h7FFFFF;
    if (t < -35'sd8388608) return 24'h800000;
    return t[23:0];
  endfunction

  sqvs_pkg::div_t f_dl, f_dr, f_dt, f_db;
  logic [16:0]    q_l, q_r, q_t, q_b;
  logic [23:0]    b_vx [4];
  logic [23:0]    b_vy [4];
  logic [16:0]    b_ul, b_ur, b_vt, b_vb;

  assign f_dl = sqvs_pkg::div_step4(s4_dl, sw);
  assign f_dr = sqvs_pkg::div_step4(s4_dr, sw);
  assign f_dt = sqvs_pkg::div_step4(s4_dt, sh);
  assign f_db = sqvs_pkg::div_step4(s4_db, sh);
  assign q_l  = sqvs_pkg::div_result(f_dl);
  assign q_r  = sqvs_pkg::div_result(f_dr);
  assign q_t  = sqvs_pkg::div_result(f_dt);
  assign q_b  = sqvs_pkg::div_result(f_db);

  always_ff @(posedge clk) begin
    if (en_buf) begin
      for (int k = 0; k < 4; k++) begin
        b_vx[k] <= sat_vert(s4_px, s4_rx[k]);
        b_vy[k] <= sat_vert(s4_py, s4_ry[k]);
      end
      if (use_texture_region) begin
        b_ul <= q_l;
        b_ur <= q_r;
        b_vt <= flip_v ? q_b : q_t;
        b_vb <= flip_v ? q_t : q_b;
      end else begin
        b_ul <= sqvs_pkg::TEX_HALF;
        b_ur <= sqvs_pkg::TEX_HALF;
        b_vt <= sqvs_pkg::TEX_HALF;
        b_vb <= sqvs_pkg::TEX_HALF;
      end
    end
  end

  assign m_tvalid = fv;
  assign m_tlast  = (cnt == 2'd3);
  assign m_tdata  = {4'd0,
                     cnt[1] ? b_vb : b_vt,
                     cnt[0] ? b_ur : b_ul,
                     b_vy[cnt],
                     b_vx[cnt],
                     cnt};

endmodule

### hdl/sqvs_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sqvs_checker
// Port-level checks on the corner output sequence, bound to the top level.
// ----------------------------------------------------------------------------
module sqvs_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [87:0] m_tdata,
  input logic        m_tlast
);

  // tlast marks exactly the bottom-right corner
  a_last_corner: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tlast == (m_tdata[1:0] == 2'd3)))
    else $error("tlast does not match corner index");

  // the corners of one sprite come back to back in order
  a_corner_order: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && !m_tlast) |=>
      (m_tvalid && (m_tdata[1:0] == 2'($past(m_tdata[1:0]) + 2'd1))))
    else $error("corner sequence broken");

  // a new sprite starts at top-left
  a_first_corner: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && m_tlast) |=> (!m_tvalid || (m_tdata[1:0] == 2'd0)))
    else $error("sprite does not start at top-left");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled transaction changed");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid right after reset");

endmodule

bind sprite_quad_vertex_setup sqvs_checker u_sqvs_checker (
  .clk     (clk),
  .rst     (rst),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata),
  .m_tlast (m_tlast)
);
